// ----- src/sha_pkg.sv -----
// Shared types, constants and SHA-256 functions for the byte stream hasher.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sha_pkg;

	localparam int WORD_W   = 32;
	localparam int NUM_WORDS = 8;
	localparam int WIN_WORDS = 16;
	localparam int ROUNDS   = 64;

	localparam logic [5:0] FILL_LAST  = 6'd63;
	localparam logic [5:0] FILL_LEN   = 6'd56;
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [7:0] PAD_ZERO   = 8'h00;
	localparam logic [63:0] BITS_PER_BYTE = 64'd8;

	localparam logic ACT_ABSORB = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	localparam logic [WORD_W-1:0] INIT_H [NUM_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MARK,
		ST_ZERO,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_DONE
	} sha_state_t;

	typedef struct packed {
		logic       byte_load;
		logic [7:0] byte_data;
		logic       round_start;
		logic       round_en;
		logic [5:0] round_idx;
		logic       chain_add;
		logic       chain_init;
		logic       out_load;
	} sha_ctl_t;

	function automatic logic [WORD_W-1:0] ssig0(input logic [WORD_W-1:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic logic [WORD_W-1:0] ssig1(input logic [WORD_W-1:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

	function automatic logic [WORD_W-1:0] bsig0(input logic [WORD_W-1:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [WORD_W-1:0] bsig1(input logic [WORD_W-1:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [WORD_W-1:0] ch_fn(input logic [WORD_W-1:0] e,
			input logic [WORD_W-1:0] f, input logic [WORD_W-1:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [WORD_W-1:0] maj_fn(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

`default_nettype wire

// ----- src/sha_in_if.sv -----
// Input channel of the hasher: one message byte or a finish command per beat.
// Depends on nothing.
`default_nettype none

interface sha_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] byte_value;

	modport source (output valid, output action, output byte_value, input ready);
	modport sink (input valid, input action, input byte_value, output ready);
endinterface

`default_nettype wire

// ----- src/sha_out_if.sv -----
// Output channel of the hasher: one 256-bit digest per beat, as eight words.
// Depends on nothing.
`default_nettype none

interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word0;
	logic [31:0] digest_word1;
	logic [31:0] digest_word2;
	logic [31:0] digest_word3;
	logic [31:0] digest_word4;
	logic [31:0] digest_word5;
	logic [31:0] digest_word6;
	logic [31:0] digest_word7;

	modport source (output valid, output digest_word0, output digest_word1,
		output digest_word2, output digest_word3, output digest_word4,
		output digest_word5, output digest_word6, output digest_word7, input ready);
	modport sink (input valid, input digest_word0, input digest_word1,
		input digest_word2, input digest_word3, input digest_word4,
		input digest_word5, input digest_word6, input digest_word7, output ready);
endinterface

`default_nettype wire

// ----- src/sha256_byte_stream_hasher.sv -----
// SHA-256 byte stream hasher: one message byte accepted per cycle while the block buffer fills.
// The 64th byte of a block is followed by 64 rounds of the shared round unit and one add.
// A finish beat is followed by the 0x80 marker byte, the zero bytes up to byte 56, the 8 length
// bytes, the compression of each full block and the loading of the digest, which waits while
// the digest register is held. No byte is accepted while a block is being compressed.
// Reset (arst_n low, asynchronous) loads the initial hash values and clears all counters.
`default_nettype none

module sha256_byte_stream_hasher
	import sha_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	sha_in_if.sink    msg,
	sha_out_if.source digest
);

	// The sequencer owns every counter: the block fill level, the round index and the
	// 64-bit message bit count. During padding it generates the 0x80 marker, the zero
	// bytes and the big-endian length itself, so the datapath sees one byte stream.
	sha_ctl_t          ctl;
	logic [WORD_W-1:0] w_cur;
	logic [WORD_W-1:0] chain [NUM_WORDS];
	logic [WORD_W-1:0] dig_q [NUM_WORDS];

	sha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (msg.valid),
		.in_action (msg.action),
		.in_byte   (msg.byte_value),
		.in_ready  (msg.ready),
		.out_ready (digest.ready),
		.out_valid (digest.valid),
		.ctl       (ctl)
	);

	// The window doubles as the block buffer and the 16-word schedule: bytes shift in
	// during intake, and during the rounds each new schedule word shifts in behind.
	sha_window u_window (
		.clk   (clk),
		.ctl   (ctl),
		.w_cur (w_cur)
	);

	// One round per cycle through a single shared round unit.
	sha_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.w_cur  (w_cur),
		.chain  (chain)
	);

	// The digest sits in its own register, so a new message can be absorbed while the
	// previous digest still waits to be taken. A second finish waits in its last state
	// until this register is free.
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			dig_q <= chain;
		end
	end

	assign digest.digest_word0 = dig_q[0];
	assign digest.digest_word1 = dig_q[1];
	assign digest.digest_word2 = dig_q[2];
	assign digest.digest_word3 = dig_q[3];
	assign digest.digest_word4 = dig_q[4];
	assign digest.digest_word5 = dig_q[5];
	assign digest.digest_word6 = dig_q[6];
	assign digest.digest_word7 = dig_q[7];

endmodule

`default_nettype wire

// ----- src/sha_window.sv -----
// Message window: gathers bytes into a 16-word block and expands the schedule.
// Depends on sha_pkg.
`default_nettype none

module sha_window
	import sha_pkg::*;
(
	input  wire logic              clk,
	input  wire sha_ctl_t          ctl,
	output logic [WORD_W-1:0]      w_cur
);

	// Entry 15 is the oldest word, the one the current round consumes.
	logic [WIN_WORDS-1:0][WORD_W-1:0] win_q;
	logic [WORD_W-1:0]                w_new;

	// W[t+16] from W[t], W[t+1], W[t+9] and W[t+14].
	assign w_new = win_q[15] + ssig0(win_q[14]) + win_q[6] + ssig1(win_q[1]);
	assign w_cur = win_q[15];

	always_ff @(posedge clk) begin
		if (ctl.byte_load) begin
			win_q <= {win_q[15][23:0], win_q[14:0], ctl.byte_data};
		end else if (ctl.round_en) begin
			win_q <= {win_q[14:0], w_new};
		end
	end

endmodule

`default_nettype wire

// ----- src/sha_compress.sv -----
// Compression unit: working variables, one shared round per cycle, chaining words.
// Depends on sha_pkg.
`default_nettype none

module sha_compress
	import sha_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sha_ctl_t          ctl,
	input  wire logic [WORD_W-1:0] w_cur,
	output logic [WORD_W-1:0]      chain [NUM_WORDS]
);

	logic [WORD_W-1:0] h_q [NUM_WORDS];
	logic [WORD_W-1:0] r_q [NUM_WORDS];
	logic [WORD_W-1:0] t1;
	logic [WORD_W-1:0] t2;

	assign t1 = r_q[7] + bsig1(r_q[4]) + ch_fn(r_q[4], r_q[5], r_q[6])
		+ ROUND_K[ctl.round_idx] + w_cur;
	assign t2 = bsig0(r_q[0]) + maj_fn(r_q[0], r_q[1], r_q[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				h_q[i] <= INIT_H[i];
			end
		end else if (ctl.chain_init) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				h_q[i] <= INIT_H[i];
			end
		end else if (ctl.chain_add) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				h_q[i] <= h_q[i] + r_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.round_start) begin
			r_q <= h_q;
		end else if (ctl.round_en) begin
			r_q[0] <= t1 + t2;
			r_q[1] <= r_q[0];
			r_q[2] <= r_q[1];
			r_q[3] <= r_q[2];
			r_q[4] <= r_q[3] + t1;
			r_q[5] <= r_q[4];
			r_q[6] <= r_q[5];
			r_q[7] <= r_q[6];
		end
	end

	assign chain = h_q;

endmodule

`default_nettype wire

// ----- src/sha_ctrl.sv -----
// Sequencer: byte intake, padding, round counting and the result handshake.
// Depends on sha_pkg; drives sha_window and sha_compress through sha_ctl_t.
`default_nettype none

module sha_ctrl
	import sha_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_action,
	input  wire logic [7:0] in_byte,
	output logic            in_ready,
	input  wire logic       out_ready,
	output logic            out_valid,
	output sha_ctl_t        ctl
);

	sha_state_t  state_q, state_d;
	sha_state_t  ret_q, ret_d;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [63:0] bits_q;
	logic        out_valid_q;
	logic        out_free;
	logic        absorb;

	assign out_free = !out_valid_q || out_ready;
	assign absorb   = (state_q == ST_IDLE) && in_valid && (in_action == ACT_ABSORB);

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_action == ACT_FINISH) begin
						state_d = ST_MARK;
					end else if (fill_q == FILL_LAST) begin
						state_d = ST_ROUND;
						ret_d   = ST_IDLE;
					end
				end
			end
			ST_MARK: begin
				state_d = ST_ZERO;
				if (fill_q == FILL_LAST) begin
					state_d = ST_ROUND;
					ret_d   = ST_ZERO;
				end
			end
			ST_ZERO: begin
				if (fill_q == FILL_LEN) begin
					state_d = ST_LEN;
				end else if (fill_q == FILL_LAST) begin
					state_d = ST_ROUND;
					ret_d   = ST_ZERO;
				end
			end
			ST_LEN: begin
				if (fill_q == FILL_LAST) begin
					state_d = ST_ROUND;
					ret_d   = ST_DONE;
				end
			end
			ST_ROUND: begin
				if (rnd_q == ROUND_LAST) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				state_d = ret_q;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (absorb) begin
					ctl.byte_load = 1'b1;
					ctl.byte_data = in_byte;
				end
			end
			ST_MARK: begin
				ctl.byte_load = 1'b1;
				ctl.byte_data = PAD_MARK;
			end
			ST_ZERO: begin
				if (fill_q != FILL_LEN) begin
					ctl.byte_load = 1'b1;
					ctl.byte_data = PAD_ZERO;
				end
			end
			ST_LEN: begin
				ctl.byte_load = 1'b1;
				ctl.byte_data = bits_q[63:56];
			end
			ST_ROUND: begin
				ctl.round_en  = 1'b1;
				ctl.round_idx = rnd_q;
			end
			ST_ADD: begin
				ctl.chain_add = 1'b1;
			end
			ST_DONE: begin
				ctl.out_load   = out_free;
				ctl.chain_init = out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
		ctl.round_start = ctl.byte_load && (fill_q == FILL_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			fill_q      <= '0;
			rnd_q       <= '0;
			bits_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (ctl.byte_load) begin
				fill_q <= fill_q + 6'd1;
			end
			if (ctl.round_en) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (ctl.chain_init) begin
				bits_q <= '0;
			end else if (absorb) begin
				bits_q <= bits_q + BITS_PER_BYTE;
			end else if (state_q == ST_LEN) begin
				bits_q <= {bits_q[55:0], 8'h00};
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_round_start: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.round_start |=> (state_q == ST_ROUND) && (rnd_q == 6'd0))
		else $error("compression did not start at round zero");

	a_add_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |-> (fill_q == 6'd0))
		else $error("block not empty while adding chaining words");

	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LEN) |-> (fill_q >= FILL_LEN))
		else $error("length bytes placed before byte 56");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |=> out_valid_q && (state_q == ST_IDLE))
		else $error("digest load did not raise valid and return to idle");

endmodule

`default_nettype wire
